// ===== hdl/piaw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller package
// Shared widths, register indexes, reset values, command and status types.
// ----------------------------------------------------------------------------
package piaw_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam int IO_W       = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 32;
  localparam int PERIOD_W   = 24;
  localparam int LIMIT_W    = 31;
  localparam int ERR_W      = 33;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int TERM_W     = 48;
  localparam int SUM_W      = 52;
  localparam int DMAG_W     = 51;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 2'd3;

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 32'd65536;
  localparam logic [GAIN_W-1:0]   INTEGRAL_GAIN_RST = 32'd0;
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 24'd1678;
  localparam logic [LIMIT_W-1:0]  OUTPUT_LIMIT_RST  = 31'h7FFF_FFFF;

  // one tenth in Q0.16
  localparam logic [MUL_W-1:0] BACK_Q16 = 32'd6554;

  typedef struct packed {
    logic capture;
    logic mag;
    logic mul_ki;
    logic mul_kp;
    logic mul_sp_lo;
    logic mul_sp_hi;
    logic inc;
    logic iadd;
    logic iclamp;
    logic unsat;
    logic oclamp;
    logic publish;
    logic keep_integ;
    logic mul_bc_lo;
    logic mul_bc_hi;
    logic bterm;
    logic badd;
    logic bclamp;
  } cmd_t;

  typedef struct packed {
    logic sat;
  } sts_t;

  function automatic logic signed [SUM_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] lim
  );
    logic signed [SUM_W-1:0] res;
    res = v;
    if (v > lim) begin
      res = lim;
    end else if (v < -lim) begin
      res = -lim;
    end
    return res;
  endfunction

endpackage

// ===== hdl/pi_controller_anti_windup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller with back-calculation anti-windup
// Fixed-point Q16.16 PI loop with clamped output and integrator.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. The result register is loaded at
// the publish step and, when the output clamp does not act, the next
// transaction can be accepted in the cycle after it; when the clamp acts,
// the back-calculation steps update the integrator before the next
// acceptance. The sequence is set by the single shared 32x32 multiplier
// (three products for the integral term, one for the proportional term, two
// for back-calculation) and one wide add or clamp per step. A result waiting
// in the output register holds the block only at the publish step.
// Any configuration write clears the integrator.
module pi_controller_anti_windup #(
  parameter int DATA_WIDTH = piaw_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [piaw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [piaw_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [piaw_pkg::IO_W-1:0]       in_reference,
  input  logic signed [piaw_pkg::IO_W-1:0]       in_feedback,
  input  logic signed [piaw_pkg::IO_W-1:0]       in_feedforward,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [piaw_pkg::IO_W-1:0]       out_drive,
  output logic                                   out_saturated
);

  piaw_pkg::cmd_t cmd;
  piaw_pkg::sts_t sts;

  piaw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  piaw_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_reference   (in_reference),
    .in_feedback    (in_feedback),
    .in_feedforward (in_feedforward),
    .out_drive      (out_drive),
    .out_saturated  (out_saturated),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== hdl/piaw_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32x32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module piaw_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic [piaw_pkg::MUL_W-1:0]         op_a,
  input  logic [piaw_pkg::MUL_W-1:0]         op_b,
  output logic [piaw_pkg::PROD_W-1:0]        prod
);

  logic [piaw_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

// ===== hdl/piaw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller sequencer
// Steps one transaction through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module piaw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  piaw_pkg::sts_t       sts,
  output piaw_pkg::cmd_t       cmd
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_MAG    = 17'b00000000000000010,
    S_MKI    = 17'b00000000000000100,
    S_MKP    = 17'b00000000000001000,
    S_MSL    = 17'b00000000000010000,
    S_MSH    = 17'b00000000000100000,
    S_INC    = 17'b00000000001000000,
    S_IADD   = 17'b00000000010000000,
    S_ICLP   = 17'b00000000100000000,
    S_UNSAT  = 17'b00000001000000000,
    S_OCLP   = 17'b00000010000000000,
    S_OUT    = 17'b00000100000000000,
    S_MBL    = 17'b00001000000000000,
    S_MBH    = 17'b00010000000000000,
    S_BTERM  = 17'b00100000000000000,
    S_BADD   = 17'b01000000000000000,
    S_BCLP   = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   publish;

  assign slot_free = !out_valid_r || !out_stall;
  assign publish   = (state_r == S_OUT) && slot_free;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MAG;
      S_MAG:   state_nxt = S_MKI;
      S_MKI:   state_nxt = S_MKP;
      S_MKP:   state_nxt = S_MSL;
      S_MSL:   state_nxt = S_MSH;
      S_MSH:   state_nxt = S_INC;
      S_INC:   state_nxt = S_IADD;
      S_IADD:  state_nxt = S_ICLP;
      S_ICLP:  state_nxt = S_UNSAT;
      S_UNSAT: state_nxt = S_OCLP;
      S_OCLP:  state_nxt = S_OUT;
      S_OUT: begin
        if (slot_free) begin
          state_nxt = sts.sat ? S_MBL : S_IDLE;
        end
      end
      S_MBL:   state_nxt = S_MBH;
      S_MBH:   state_nxt = S_BTERM;
      S_BTERM: state_nxt = S_BADD;
      S_BADD:  state_nxt = S_BCLP;
      S_BCLP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state_r == S_IDLE) && in_valid;
    cmd.mag        = (state_r == S_MAG);
    cmd.mul_ki     = (state_r == S_MKI);
    cmd.mul_kp     = (state_r == S_MKP);
    cmd.mul_sp_lo  = (state_r == S_MSL);
    cmd.mul_sp_hi  = (state_r == S_MSH);
    cmd.inc        = (state_r == S_INC);
    cmd.iadd       = (state_r == S_IADD);
    cmd.iclamp     = (state_r == S_ICLP);
    cmd.unsat      = (state_r == S_UNSAT);
    cmd.oclamp     = (state_r == S_OCLP);
    cmd.publish    = publish;
    cmd.keep_integ = publish && !sts.sat;
    cmd.mul_bc_lo  = (state_r == S_MBL);
    cmd.mul_bc_hi  = (state_r == S_MBH);
    cmd.bterm      = (state_r == S_BTERM);
    cmd.badd       = (state_r == S_BADD);
    cmd.bclamp     = (state_r == S_BCLP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/piaw_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller datapath
// Gain registers, integrator, shared multiplier, wide adders and clamps.
// ----------------------------------------------------------------------------
module piaw_dpath #(
  parameter int DATA_WIDTH = piaw_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [piaw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [piaw_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [piaw_pkg::IO_W-1:0]       in_reference,
  input  logic signed [piaw_pkg::IO_W-1:0]       in_feedback,
  input  logic signed [piaw_pkg::IO_W-1:0]       in_feedforward,
  output logic signed [piaw_pkg::IO_W-1:0]       out_drive,
  output logic                                   out_saturated,
  input  piaw_pkg::cmd_t                         cmd,
  output piaw_pkg::sts_t                         sts
);

  localparam int SUM_W  = piaw_pkg::SUM_W;
  localparam int IO_W   = piaw_pkg::IO_W;
  localparam int MUL_W  = piaw_pkg::MUL_W;
  localparam int PROD_W = piaw_pkg::PROD_W;
  localparam int TERM_W = piaw_pkg::TERM_W;
  localparam int DMAG_W = piaw_pkg::DMAG_W;
  localparam int ERR_W  = piaw_pkg::ERR_W;
  localparam logic signed [SUM_W-1:0] WMAX =
    (SUM_W'(1) << (DATA_WIDTH - 1)) - SUM_W'(1);

  // configuration
  logic [piaw_pkg::GAIN_W-1:0]   kp_r;
  logic [piaw_pkg::GAIN_W-1:0]   ki_r;
  logic [piaw_pkg::PERIOD_W-1:0] sp_r;
  logic [piaw_pkg::LIMIT_W-1:0]  lim_cfg_r;
  logic signed [DATA_WIDTH-1:0]  integ_r;

  // per-transaction working registers
  logic signed [ERR_W-1:0]  err_r;
  logic signed [IO_W-1:0]   ff_r;
  logic signed [SUM_W-1:0]  lim_r;
  logic [MUL_W-1:0]         emag_r;
  logic                     eneg_r;
  logic [PROD_W-1:0]        p_r;
  logic [TERM_W-1:0]        propm_r;
  logic [PROD_W-1:0]        lo_r;
  logic [TERM_W-1:0]        incm_r;
  logic signed [SUM_W-1:0]  isum_r;
  logic signed [SUM_W-1:0]  icl_r;
  logic signed [SUM_W-1:0]  unsat_r;
  logic signed [IO_W-1:0]   drive_r;
  logic                     sat_r;
  logic [DMAG_W-1:0]        dmag_r;
  logic                     dneg_r;
  logic [PROD_W-1:0]        blo_r;
  logic [TERM_W-1:0]        bm_r;
  logic signed [IO_W-1:0]   out_drive_r;
  logic                     out_sat_r;

  // combinational
  logic signed [SUM_W-1:0]  lim_nxt;
  logic signed [SUM_W-1:0]  lim_cfg_ext;
  logic signed [ERR_W-1:0]  err_abs;
  logic signed [SUM_W-1:0]  integ_ext;
  logic signed [SUM_W-1:0]  incm_ext;
  logic signed [SUM_W-1:0]  propm_ext;
  logic signed [SUM_W-1:0]  bm_ext;
  logic signed [SUM_W-1:0]  ff_ext;
  logic signed [SUM_W-1:0]  neg_lim;
  logic                     over_pos;
  logic                     over_neg;
  logic signed [SUM_W-1:0]  drive_full;
  logic signed [SUM_W-1:0]  dmag_full;
  logic signed [SUM_W-1:0]  bcl_full;
  logic [PROD_W-1:0]        inc_sum;
  logic [PROD_W-1:0]        bc_sum;
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic                     mul_en;
  logic [PROD_W-1:0]        prod;

  assign lim_cfg_ext = SUM_W'(lim_cfg_r);
  assign lim_nxt     = (lim_cfg_ext > WMAX) ? WMAX : lim_cfg_ext;
  assign err_abs     = err_r[ERR_W-1] ? -err_r : err_r;
  assign integ_ext   = {{(SUM_W - DATA_WIDTH){integ_r[DATA_WIDTH-1]}}, integ_r};
  assign incm_ext    = {{(SUM_W - TERM_W){1'b0}}, incm_r};
  assign propm_ext   = {{(SUM_W - TERM_W){1'b0}}, propm_r};
  assign bm_ext      = {{(SUM_W - TERM_W){1'b0}}, bm_r};
  assign ff_ext      = {{(SUM_W - IO_W){ff_r[IO_W-1]}}, ff_r};
  assign neg_lim     = -lim_r;
  assign over_pos    = unsat_r > lim_r;
  assign over_neg    = unsat_r < neg_lim;
  assign drive_full  = over_pos ? lim_r : (over_neg ? neg_lim : unsat_r);
  assign dmag_full   = over_pos ? (unsat_r - lim_r) : (neg_lim - unsat_r);
  assign bcl_full    = piaw_pkg::clamp_sym(isum_r, lim_r);
  assign inc_sum     = prod + (lo_r >> MUL_W);
  assign bc_sum      = {prod[MUL_W-1:0], {MUL_W{1'b0}}} + blo_r;

  always_comb begin
    mul_a  = emag_r;
    mul_b  = ki_r;
    mul_en = 1'b1;
    if (cmd.mul_kp) begin
      mul_b = kp_r;
    end else if (cmd.mul_sp_lo) begin
      mul_a = p_r[MUL_W-1:0];
      mul_b = MUL_W'(sp_r);
    end else if (cmd.mul_sp_hi) begin
      mul_a = p_r[PROD_W-1:MUL_W];
      mul_b = MUL_W'(sp_r);
    end else if (cmd.mul_bc_lo) begin
      mul_a = dmag_r[MUL_W-1:0];
      mul_b = piaw_pkg::BACK_Q16;
    end else if (cmd.mul_bc_hi) begin
      mul_a = {{(PROD_W - DMAG_W){1'b0}}, dmag_r[DMAG_W-1:MUL_W]};
      mul_b = piaw_pkg::BACK_Q16;
    end else if (!cmd.mul_ki) begin
      mul_en = 1'b0;
    end
  end

  piaw_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // configuration registers and integrator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= piaw_pkg::PROP_GAIN_RST;
      ki_r      <= piaw_pkg::INTEGRAL_GAIN_RST;
      sp_r      <= piaw_pkg::SAMPLE_PERIOD_RST;
      lim_cfg_r <= piaw_pkg::OUTPUT_LIMIT_RST;
      integ_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        piaw_pkg::REG_PROP_GAIN:     kp_r      <= cfg_data[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_INTEGRAL_GAIN: ki_r      <= cfg_data[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_SAMPLE_PERIOD: sp_r      <= cfg_data[piaw_pkg::PERIOD_W-1:0];
        piaw_pkg::REG_OUTPUT_LIMIT:  lim_cfg_r <= cfg_data[piaw_pkg::LIMIT_W-1:0];
        default: ;
      endcase
      integ_r <= '0;
    end else if (cmd.keep_integ) begin
      integ_r <= icl_r[DATA_WIDTH-1:0];
    end else if (cmd.bclamp) begin
      integ_r <= bcl_full[DATA_WIDTH-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err_r <= {in_reference[IO_W-1], in_reference} - {in_feedback[IO_W-1], in_feedback};
      ff_r  <= in_feedforward;
      lim_r <= lim_nxt;
    end
    if (cmd.mag) begin
      emag_r <= err_abs[MUL_W-1:0];
      eneg_r <= err_r[ERR_W-1];
    end
    if (cmd.mul_kp) begin
      p_r <= prod;
    end
    if (cmd.mul_sp_lo) begin
      propm_r <= prod[TERM_W+15:16];
    end
    if (cmd.mul_sp_hi) begin
      lo_r <= prod;
    end
    if (cmd.inc) begin
      incm_r <= inc_sum[TERM_W+7:8];
    end
    if (cmd.iadd) begin
      isum_r <= eneg_r ? (integ_ext - incm_ext) : (integ_ext + incm_ext);
    end else if (cmd.badd) begin
      isum_r <= dneg_r ? (icl_r - bm_ext) : (icl_r + bm_ext);
    end
    if (cmd.iclamp) begin
      icl_r <= piaw_pkg::clamp_sym(isum_r, lim_r);
    end
    if (cmd.unsat) begin
      unsat_r <= eneg_r ? (icl_r + ff_ext - propm_ext) : (icl_r + ff_ext + propm_ext);
    end
    if (cmd.oclamp) begin
      drive_r <= drive_full[IO_W-1:0];
      sat_r   <= over_pos || over_neg;
      dmag_r  <= dmag_full[DMAG_W-1:0];
      dneg_r  <= over_pos;
    end
    if (cmd.mul_bc_hi) begin
      blo_r <= prod;
    end
    if (cmd.bterm) begin
      bm_r <= bc_sum[TERM_W+15:16];
    end
    if (cmd.publish) begin
      out_drive_r <= drive_r;
      out_sat_r   <= sat_r;
    end
  end

  assign sts.sat       = sat_r;
  assign out_drive     = out_drive_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== hdl/piaw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller port checker
// Watches the top-level ports for handshake and clamp consistency.
// ----------------------------------------------------------------------------
module piaw_checker #(
  parameter int DATA_WIDTH = piaw_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [piaw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [piaw_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [piaw_pkg::IO_W-1:0]       out_drive,
  input  logic                                   out_saturated
);

  localparam int LW = piaw_pkg::SUM_W;
  localparam logic signed [LW-1:0] WMAX = (LW'(1) << (DATA_WIDTH - 1)) - LW'(1);

  logic [piaw_pkg::LIMIT_W-1:0] lim_q_r;
  logic signed [LW-1:0]         lim_raw;
  logic signed [LW-1:0]         lim_eff;
  logic signed [LW-1:0]         drive_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_q_r <= piaw_pkg::OUTPUT_LIMIT_RST;
    end else if (cfg_wr_en && (cfg_index == piaw_pkg::REG_OUTPUT_LIMIT)) begin
      lim_q_r <= cfg_data[piaw_pkg::LIMIT_W-1:0];
    end
  end

  assign lim_raw   = LW'(lim_q_r);
  assign lim_eff   = (lim_raw > WMAX) ? WMAX : lim_raw;
  assign drive_ext = {{(LW - piaw_pkg::IO_W){out_drive[piaw_pkg::IO_W-1]}}, out_drive};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive) && $stable(out_saturated))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (drive_ext <= lim_eff) && (drive_ext >= -lim_eff))
    else $error("drive outside the output limit");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (drive_ext == lim_eff) || (drive_ext == -lim_eff))
    else $error("saturated flag without drive at the limit");

endmodule

bind pi_controller_anti_windup piaw_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_piaw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_drive     (out_drive),
  .out_saturated (out_saturated)
);
